// ===== design/csv_byte_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// csv_byte_tokenizer_defines.svh
// Assertion macros shared by csv_byte_tokenizer and csvt_queue.
// ----------------------------------------------------------------------------
`ifndef CSV_BYTE_TOKENIZER_DEFINES_SVH
`define CSV_BYTE_TOKENIZER_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define CSVT_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define CSVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and constants of the CSV byte tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

	// Token kinds
	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_FIELD  = 2'd1,
		KIND_RECORD = 2'd2,
		KIND_FILE   = 2'd3
	} kind_t;

	// Scanner mode
	typedef enum logic [1:0] {
		MODE_NORMAL     = 2'd0,
		MODE_QUOTED     = 2'd1,
		MODE_QUOTE_SEEN = 2'd2,
		MODE_CR_SEEN    = 2'd3
	} mode_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DELIMITER = 2'd0,
		REG_QUOTE     = 2'd1,
		REG_UNIX_EOL  = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	localparam logic [7:0] CHAR_CR        = 8'h0D;
	localparam logic [7:0] CHAR_LF        = 8'h0A;
	localparam logic [7:0] DELIM_RESET    = 8'h2C;
	localparam logic [7:0] QUOTE_RESET    = 8'h22;

	// Token queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration values
	typedef struct packed {
		logic [7:0] delimiter;
		logic [7:0] quote_char;
		logic       unix_eol;
	} cfg_t;

	// One result token
	typedef struct packed {
		kind_t      kind;
		logic [7:0] tbyte;
		logic       last;
	} token_t;

	// Up to two tokens produced by one input word
	typedef struct packed {
		logic [1:0] n;
		token_t     t0;
		token_t     t1;
	} push_t;

endpackage

// ===== design/csv_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_byte_tokenizer
// CSV byte stream to token stream (data byte, end of field/record/file).
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  s_*     | in        | s_tvalid / s_tready    | tdata data_byte, tuser req_type
//  m_*     | out       | m_tvalid / m_tready    | tdata token_byte, tuser kind,
//          |           |                        | tlast last_of_run
//  cfg_*   | in        | cfg_we                 | cfg_index, cfg_wdata
//
// One input word a cycle is taken into the input register while s_tready
// is high; it is decoded there, and its zero, one or two tokens enter a
// four-entry queue as it leaves. A word leaves the input register only while
// the queue has room for two tokens, so sustained rate is one word a cycle
// while tokens drain as fast. Tokens pass the input register, then the queue.
// Reset clears mode, queue and input register; configuration returns to
// delimiter ',', quote '"', CR LF line ends.
// ----------------------------------------------------------------------------
`include "csv_byte_tokenizer_defines.svh"

module csv_byte_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] req_type
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] token_byte
	output logic [1:0] m_tuser,   // [1:0] token_kind
	output logic       m_tlast,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);
	import csvt_pkg::*;

	cfg_t       cfg_q;
	mode_t      mode_q, mode_nxt;
	logic       valid_s1;
	logic       end_s1;
	logic [7:0] byte_s1;
	logic       room, advance;
	push_t      scan_push, push;
	token_t     out_tok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter  <= DELIM_RESET;
			cfg_q.quote_char <= QUOTE_RESET;
			cfg_q.unix_eol   <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DELIMITER: cfg_q.delimiter  <= cfg_wdata;
				REG_QUOTE:     cfg_q.quote_char <= cfg_wdata;
				REG_UNIX_EOL:  cfg_q.unix_eol   <= cfg_wdata[0];
				REG_UNUSED: begin
				end
				default: begin
				end
			endcase
		end
	end

	// input register
	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			end_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// mode register, updated as each word is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (advance) begin
			mode_q <= mode_nxt;
		end
	end

	csvt_scan u_scan (
		.cfg      (cfg_q),
		.mode     (mode_q),
		.req_end  (end_s1),
		.c        (byte_s1),
		.push     (scan_push),
		.mode_nxt (mode_nxt)
	);

	always_comb begin
		push   = scan_push;
		push.n = advance ? scan_push.n : 2'd0;
	end

	csvt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (out_tok)
	);

	assign m_tdata = out_tok.tbyte;
	assign m_tuser = out_tok.kind;
	assign m_tlast = out_tok.last;

	`CSVT_ASSERT_NEXT(a_s1_hold, valid_s1 && !room, valid_s1 && $stable(byte_s1) && $stable(end_s1), "stalled input word changed")

endmodule

// ===== design/csvt_scan.sv =====
// ----------------------------------------------------------------------------
// csvt_scan
// Decode of one input word against the current mode: tokens and next mode.
// ----------------------------------------------------------------------------
module csvt_scan (
	input  csvt_pkg::cfg_t  cfg,
	input  csvt_pkg::mode_t mode,
	input  logic            req_end,
	input  logic [7:0]      c,
	output csvt_pkg::push_t push,
	output csvt_pkg::mode_t mode_nxt
);
	import csvt_pkg::*;

	// normal-mode handling of c
	logic  nb_emit;
	kind_t nb_kind;
	mode_t nb_mode;

	always_comb begin
		nb_emit = 1'b1;
		nb_kind = KIND_BYTE;
		nb_mode = MODE_NORMAL;
		priority if (c == cfg.quote_char) begin
			nb_emit = 1'b0;
			nb_mode = MODE_QUOTED;
		end else if (c == cfg.delimiter) begin
			nb_kind = KIND_FIELD;
		end else if (!cfg.unix_eol && c == CHAR_CR) begin
			nb_emit = 1'b0;
			nb_mode = MODE_CR_SEEN;
		end else if (cfg.unix_eol && c == CHAR_LF) begin
			nb_kind = KIND_RECORD;
		end else begin
			// plain data byte
			nb_kind = KIND_BYTE;
		end
	end

	// byte field is zero for non-byte kinds
	function automatic token_t mk(kind_t k, logic [7:0] b);
		token_t t;
		t.kind  = k;
		t.tbyte = (k == KIND_BYTE) ? b : 8'h00;
		t.last  = 1'b0;
		return t;
	endfunction

	token_t t0, t1;
	logic [1:0] n;

	always_comb begin
		t0       = mk(KIND_BYTE, c);
		t1       = mk(nb_kind, c);
		n        = 2'd0;
		mode_nxt = mode;
		if (req_end) begin
			mode_nxt = MODE_NORMAL;
			if (mode == MODE_CR_SEEN) begin
				t0 = mk(KIND_BYTE, CHAR_CR);
				t1 = mk(KIND_FILE, 8'h00);
				n  = 2'd2;
			end else begin
				t0 = mk(KIND_FILE, 8'h00);
				n  = 2'd1;
			end
		end else begin
			unique case (mode)
				MODE_QUOTED: begin
					if (c == cfg.quote_char) begin
						mode_nxt = MODE_QUOTE_SEEN;
					end else begin
						n = 2'd1;
					end
				end
				MODE_QUOTE_SEEN: begin
					if (c == cfg.quote_char) begin
						mode_nxt = MODE_QUOTED;
						n        = 2'd1;
					end else begin
						t0       = mk(nb_kind, c);
						n        = {1'b0, nb_emit};
						mode_nxt = nb_mode;
					end
				end
				MODE_CR_SEEN: begin
					if (c == CHAR_LF) begin
						mode_nxt = MODE_NORMAL;
						t0       = mk(KIND_RECORD, 8'h00);
						n        = 2'd1;
					end else begin
						// pending CR goes out as data, then c in normal mode
						t0       = mk(KIND_BYTE, CHAR_CR);
						n        = nb_emit ? 2'd2 : 2'd1;
						mode_nxt = nb_mode;
					end
				end
				MODE_NORMAL: begin
					t0       = mk(nb_kind, c);
					n        = {1'b0, nb_emit};
					mode_nxt = nb_mode;
				end
				default: begin
					mode_nxt = MODE_NORMAL;
				end
			endcase
		end
	end

	// mark the final token of this word
	always_comb begin
		push    = '0;
		push.n  = n;
		push.t0 = t0;
		push.t1 = t1;
		push.t0.last = (n == 2'd1);
		push.t1.last = (n == 2'd2);
	end

endmodule

// ===== design/csvt_queue.sv =====
// ----------------------------------------------------------------------------
// csvt_queue
// Small token queue: takes up to two tokens a cycle, gives out one while out_ready is high.
// ----------------------------------------------------------------------------
`include "csv_byte_tokenizer_defines.svh"

module csvt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  csvt_pkg::push_t  push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output csvt_pkg::token_t out_tok
);
	import csvt_pkg::*;

	token_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;
	logic [QPTR_W-1:0]   wr_p1;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_tok   = mem_q[rd_q];
	assign wr_p1     = wr_q + QPTR_W'(1);
	// room for a full pair of tokens
	assign room      = (count_q <= QCNT_W'(QDEPTH - 2));

	// token storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.t0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_p1] <= push.t1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(push.n);
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

	`CSVT_ASSERT(a_no_overflow, (push.n == 2'd0) || (count_q + QCNT_W'(push.n) <= QCNT_W'(QDEPTH)), "token queue overflow")
	`CSVT_ASSERT_NEXT(a_pair_fill, (push.n == 2'd2) && !pop, count_q == $past(count_q) + QCNT_W'(2), "pair push lost a token")

endmodule
